// ----- hw/rtl/scta_pkg.sv -----
// Package for the scancode-to-ASCII queue block: payload structs, scancode
// constants and the set-1 key table. No dependencies.
`timescale 1ns / 1ps

package scta_pkg;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned CHAR_W      = 7;

  localparam logic [7:0]        SC_F12    = 8'h58;
  localparam logic [7:0]        SC_BREAK  = 8'h80;
  localparam logic [7:0]        SC_ESC    = 8'h01;
  localparam logic [CHAR_W-1:0] ASCII_ESC = 7'd27;

  typedef enum logic {
    FuncScancode = 1'b0,
    FuncRead     = 1'b1
  } func_e;

  typedef struct packed {
    logic       func;
    logic [7:0] scancode;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] echo_char;
    logic              shutdown;
    logic              dropped;
  } out_t;

  // Set-1 make code to lowercase ASCII; zero marks an unmapped key.
  function automatic logic [CHAR_W-1:0] key_rom(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'd2:    c = 7'h31;
      7'd3:    c = 7'h32;
      7'd4:    c = 7'h33;
      7'd5:    c = 7'h34;
      7'd6:    c = 7'h35;
      7'd7:    c = 7'h36;
      7'd8:    c = 7'h37;
      7'd9:    c = 7'h38;
      7'd10:   c = 7'h39;
      7'd11:   c = 7'h30;
      7'd12:   c = 7'h2d;
      7'd13:   c = 7'h3d;
      7'd16:   c = 7'h71;
      7'd17:   c = 7'h77;
      7'd18:   c = 7'h65;
      7'd19:   c = 7'h72;
      7'd20:   c = 7'h74;
      7'd21:   c = 7'h79;
      7'd22:   c = 7'h75;
      7'd23:   c = 7'h69;
      7'd24:   c = 7'h6f;
      7'd25:   c = 7'h70;
      7'd26:   c = 7'h5b;
      7'd27:   c = 7'h5d;
      7'd28:   c = 7'h0a;
      7'd30:   c = 7'h61;
      7'd31:   c = 7'h73;
      7'd32:   c = 7'h64;
      7'd33:   c = 7'h66;
      7'd34:   c = 7'h67;
      7'd35:   c = 7'h68;
      7'd36:   c = 7'h6a;
      7'd37:   c = 7'h6b;
      7'd38:   c = 7'h6c;
      7'd39:   c = 7'h3b;
      7'd40:   c = 7'h27;
      7'd41:   c = 7'h60;
      7'd43:   c = 7'h5c;
      7'd44:   c = 7'h7a;
      7'd45:   c = 7'h78;
      7'd46:   c = 7'h63;
      7'd47:   c = 7'h76;
      7'd48:   c = 7'h62;
      7'd49:   c = 7'h6e;
      7'd50:   c = 7'h6d;
      7'd51:   c = 7'h2c;
      7'd52:   c = 7'h2e;
      7'd53:   c = 7'h2f;
      7'd55:   c = 7'h2a;
      7'd57:   c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/scta_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/scancode_to_ascii_fifo_top.sv -----
// Top level of the scancode-to-ASCII queue block: key decode, queue pointers,
// output register. Depends on scta_pkg and scta_ram.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_ready_o / in_data_i): each transaction is
//   either a set-1 scancode (func = 0) or a request to read one character
//   from the queue (func = 1). Every transaction yields exactly one result.
// - Output channel (out_valid_o / out_ready_i / out_data_o): read_char,
//   echo_char, shutdown and dropped, held in an output register.
// - Configuration: cfg_we_i writes cfg_wdata_i into polled_mode at once.
//   Polled mode echoes each mapped key; interrupt mode maps 0x01 to ESC and
//   treats F12 as shutdown, after which every transaction returns zeros.
// - Timing: a scancode result is registered and ready the cycle after acceptance;
//   a read of a non-empty queue passes the queue RAM read port, then the output register.
// - Throughput: one transaction every cycle for scancodes and empty reads
//   while out_ready_i is high; during a read that fetches a character,
//   in_ready_o stays low until the RAM data reaches the output register.
// - Stall: the next transaction is taken while the output register drains
//   in the same cycle; if the receiver holds out_ready_i low, in_ready_o
//   stays low and nothing is lost.
// - Reset: pointers, halt flag and polled_mode clear; queue contents are
//   left as they are, since only written slots are ever read.

module scancode_to_ascii_fifo_top #(
  parameter int unsigned QueueDepth = scta_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scta_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scta_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CW   = scta_pkg::CHAR_W;

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  state_e          state_q;
  logic            out_valid_q;
  scta_pkg::out_t  out_q, out_d;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW-1:0] wr_nxt, rd_nxt;
  logic            halted_q;
  logic            polled_q;

  logic            accept;
  logic            is_f12;
  logic [CW-1:0]   key_char;
  logic            key_ok;
  logic            full;
  logic            empty;
  logic            ram_we;
  logic            ram_re;
  logic            out_load;
  logic [CW-1:0]   ram_rdata;

  // Hold new work back until the output register is free or draining now.
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Advance pointers with wrap at any queue depth.
  assign wr_nxt = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_nxt = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign full   = (wr_nxt == rd_ptr_q);
  assign empty  = (wr_ptr_q == rd_ptr_q);

  // Decode the scancode: F12 halts in interrupt mode, break codes drop out.
  assign is_f12   = !polled_q && (in_data_i.scancode == scta_pkg::SC_F12);
  assign key_char = (!polled_q && (in_data_i.scancode == scta_pkg::SC_ESC))
                    ? scta_pkg::ASCII_ESC
                    : scta_pkg::key_rom(in_data_i.scancode[6:0]);
  assign key_ok   = (in_data_i.func == scta_pkg::FuncScancode) && !is_f12 &&
                    ((in_data_i.scancode & scta_pkg::SC_BREAK) == 8'h00) &&
                    (key_char != '0);

  assign ram_we = accept && !halted_q && key_ok && !full;
  assign ram_re = accept && !halted_q && (in_data_i.func == scta_pkg::FuncRead) &&
                  !empty;

  // Reads and writes are sequenced by the FSM, so one slot never sees both
  // in flight at once; a read is issued only after every earlier write.
  scta_ram #(
    .Width (CW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (key_char),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Load the output register now for scancodes and empty reads, and in the
  // following StRead state for reads that wait on the RAM.
  assign out_load = (accept && !ram_re) || (state_q == StRead);

  always_comb begin
    out_d = '0;
    if (state_q == StRead) begin
      out_d.read_char = ram_rdata;
    end else if (!halted_q && (in_data_i.func == scta_pkg::FuncScancode)) begin
      out_d.shutdown  = is_f12;
      out_d.echo_char = (key_ok && polled_q) ? key_char : '0;
      out_d.dropped   = key_ok && full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      halted_q    <= 1'b0;
      polled_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        polled_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (ram_re) begin
              rd_ptr_q <= rd_nxt;
              state_q  <= StRead;
            end else begin
              out_valid_q <= 1'b1;
            end
            if (ram_we) begin
              wr_ptr_q <= wr_nxt;
            end
            if (!halted_q && (in_data_i.func == scta_pkg::FuncScancode) && is_f12) begin
              halted_q <= 1'b1;
            end
          end
        end
        StRead: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/scta_checker.sv -----
// Port-level checker for the scancode-to-ASCII queue block, bound to the top
// level. Depends on scta_pkg.
`timescale 1ns / 1ps

module scta_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input scta_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input scta_pkg::out_t out_data_o
);

  // A stalled result stays up until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Never take new work while a result is stuck in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("transaction accepted over a stalled result");

  // A scancode transaction answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.func == scta_pkg::FuncScancode)
    |=> out_valid_o)
    else $error("scancode result late");

  // A shutdown result carries nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.shutdown |->
    !out_data_o.dropped && (out_data_o.echo_char == '0) &&
    (out_data_o.read_char == '0))
    else $error("shutdown result mixed with other fields");

endmodule

bind scancode_to_ascii_fifo_top scta_checker u_scta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/tb_scancode_to_ascii_fifo_top.sv -----
// Self-checking testbench for scancode_to_ascii_fifo_top: directed, queue overflow,
// random and shutdown tests against a built-in predictor of the key queue.
// Depends on scta_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo_top;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The longest correct quiet stretch is the receiver hold of HOLD_CYCLES.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 200;
  // Settling margin after the results drain; it covers a non-empty read.
  localparam int unsigned SETTLE_CYCLES = 3;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  scta_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  scta_pkg::out_t out_data_o;
  logic           cfg_we_i;
  logic           cfg_wdata_i;

  // Traffic shaping, in percent of cycles spent idle on each side.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Set by a test to make the result side hold off for that many cycles.
  int unsigned rx_hold_req = 0;

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Predicted key-queue state and the results it has produced but not yet seen.
  logic [scta_pkg::CHAR_W-1:0] kq_mem [scta_pkg::QUEUE_DEPTH];
  int unsigned                 kq_wr;
  int unsigned                 kq_rd;
  logic                        kq_halted;
  logic                        kq_polled;
  scta_pkg::out_t              key_results_due [$];

  scancode_to_ascii_fifo_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Set-1 make code to lowercase ASCII, zero where no character is assigned.
  function automatic logic [scta_pkg::CHAR_W-1:0] key_char(input logic [6:0] code);
    logic [scta_pkg::CHAR_W-1:0] ch;
    case (code)
      7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;  7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;  7'h09: ch = 7'h38;
      7'h0a: ch = 7'h39;  7'h0b: ch = 7'h30;  7'h0c: ch = 7'h2d;  7'h0d: ch = 7'h3d;
      7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;  7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;
      7'h18: ch = 7'h6f;  7'h19: ch = 7'h70;  7'h1a: ch = 7'h5b;  7'h1b: ch = 7'h5d;
      7'h1c: ch = 7'h0a;  7'h1e: ch = 7'h61;  7'h1f: ch = 7'h73;
      7'h20: ch = 7'h64;  7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
      7'h24: ch = 7'h6a;  7'h25: ch = 7'h6b;  7'h26: ch = 7'h6c;  7'h27: ch = 7'h3b;
      7'h28: ch = 7'h27;  7'h29: ch = 7'h60;  7'h2b: ch = 7'h5c;  7'h2c: ch = 7'h7a;
      7'h2d: ch = 7'h78;  7'h2e: ch = 7'h63;  7'h2f: ch = 7'h76;
      7'h30: ch = 7'h62;  7'h31: ch = 7'h6e;  7'h32: ch = 7'h6d;  7'h33: ch = 7'h2c;
      7'h34: ch = 7'h2e;  7'h35: ch = 7'h2f;  7'h37: ch = 7'h2a;  7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // Advance the predicted queue by one accepted transaction and return its result.
  function automatic scta_pkg::out_t decode_keystroke(input scta_pkg::in_t k);
    scta_pkg::out_t              r;
    logic [scta_pkg::CHAR_W-1:0] ch;
    int unsigned                 nxt;
    r = '0;
    if (kq_halted) return r;
    if (k.func == scta_pkg::FuncRead) begin
      if (kq_rd != kq_wr) begin
        r.read_char = kq_mem[kq_rd];
        kq_rd = (kq_rd + 1) % scta_pkg::QUEUE_DEPTH;
      end
    end else if (!kq_polled && k.scancode == scta_pkg::SC_F12) begin
      r.shutdown = 1'b1;
      kq_halted  = 1'b1;
    end else if ((k.scancode & scta_pkg::SC_BREAK) == '0) begin
      if (!kq_polled && k.scancode == scta_pkg::SC_ESC) ch = scta_pkg::ASCII_ESC;
      else ch = key_char(k.scancode[6:0]);
      if (ch != '0) begin
        nxt = (kq_wr + 1) % scta_pkg::QUEUE_DEPTH;
        if (kq_polled) r.echo_char = ch;
        // One slot always stays empty; a full queue drops the new character.
        if (nxt != kq_rd) begin
          kq_mem[kq_wr] = ch;
          kq_wr = nxt;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic scta_pkg::in_t key_item(input logic f, input logic [7:0] sc);
    scta_pkg::in_t k;
    k.func     = f;
    k.scancode = sc;
    return k;
  endfunction

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one transaction; leave valid high afterwards so back-to-back items
  // never lower and raise it in the same step.
  task automatic send_keystroke(input scta_pkg::in_t item);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    key_results_due.push_back(decode_keystroke(item));
  endtask

  task automatic press(input logic [7:0] sc);
    send_keystroke(key_item(scta_pkg::FuncScancode, sc));
  endtask

  // The scancode byte of a read is don't-care; randomize it anyway.
  task automatic fetch();
    send_keystroke(key_item(scta_pkg::FuncRead, 8'($urandom_range(255))));
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (key_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_polled_mode(input logic mode);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    kq_polled = mode;
  endtask

  function automatic logic [7:0] mapped_make_code();
    logic [7:0] sc;
    do sc = 8'($urandom_range(63)); while (key_char(sc[6:0]) == '0);
    return sc;
  endfunction

  // Mostly mapped make codes and reads, plus break codes and raw noise.
  // F12 in interrupt mode would halt the block for good, so hold it back
  // until the shutdown test.
  function automatic scta_pkg::in_t random_keystroke(input int unsigned read_pct);
    int unsigned pick;
    logic [7:0]  sc;
    pick = $urandom_range(99);
    if (pick < read_pct) return key_item(scta_pkg::FuncRead, 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 70)      sc = mapped_make_code();
    else if (pick < 75) sc = scta_pkg::SC_ESC;
    else if (pick < 88) sc = 8'($urandom_range(255, 128));
    else                sc = 8'($urandom_range(255));
    if (!kq_polled && sc == scta_pkg::SC_F12) sc = 8'h59;
    return key_item(scta_pkg::FuncScancode, sc);
  endfunction

  // Interrupt rules: empty read, ESC, break codes incl. F12 release, unmapped.
  task automatic test_directed_interrupt();
    fetch();
    press(8'h02);
    press(8'h39);
    press(scta_pkg::SC_ESC);
    press(8'h81);
    press(scta_pkg::SC_F12 | scta_pkg::SC_BREAK);
    press(8'hff);
    press(8'h80);
    press(8'h00);
    press(8'h7f);
    press(8'h3a);
    repeat (4) fetch();
  endtask

  // Polled rules: F12 and 0x01 are plain unmapped keys, mapped keys echo.
  task automatic test_directed_polled();
    set_polled_mode(1'b1);
    press(scta_pkg::SC_F12);
    press(scta_pkg::SC_ESC);
    press(8'h10);
    press(8'h35);
    press(8'h37);
    press(8'hb5);
    repeat (4) fetch();
  endtask

  // Fill the queue behind a long receiver hold so the block stalls its input,
  // overflow it in polled mode (echo even when dropped), pause until all
  // results are back, then read it dry and past empty.
  task automatic test_queue_overflow();
    set_polled_mode(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold_req   = HOLD_CYCLES;
    repeat (scta_pkg::QUEUE_DEPTH + 12) press(mapped_make_code());
    wait_results_drained();
    repeat (scta_pkg::QUEUE_DEPTH + 3) fetch();
    wait_results_drained();
  endtask

  // Bursts that lean toward filling, balancing or draining the queue.
  task automatic test_random_traffic(input logic mode, input int unsigned tx_idle,
                                     input int unsigned rx_idle, input int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned read_pct;
    set_polled_mode(mode);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(80, 10);
      if (burst > left) burst = left;
      case ($urandom_range(2))
        0:       read_pct = 10;
        1:       read_pct = 45;
        default: read_pct = 85;
      endcase
      repeat (burst) send_keystroke(random_keystroke(read_pct));
      left -= burst;
    end
  endtask

  // F12 in interrupt mode: shutdown, then all-zero results; a config write
  // is still taken while halted but changes nothing visible.
  task automatic test_shutdown();
    set_polled_mode(1'b0);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    press(8'h10);
    press(scta_pkg::SC_F12);
    press(8'h11);
    fetch();
    press(scta_pkg::SC_F12);
    press(scta_pkg::SC_ESC);
    set_polled_mode(1'b1);
    press(8'h12);
    fetch();
    fetch();
  endtask

  // Check each result transaction against the oldest prediction, and shape
  // out_ready_i: honor a requested hold, otherwise stall at random.
  initial begin : result_checker
    int unsigned    hold_left;
    scta_pkg::out_t want;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (key_results_due.size() == 0) begin
          log_error($sformatf("result with nothing expected: %p", out_data_o));
        end else begin
          want = key_results_due.pop_front();
          if (out_data_o.read_char != want.read_char)
            log_error($sformatf("read_char got %h want %h",
                                out_data_o.read_char, want.read_char));
          if (out_data_o.echo_char != want.echo_char)
            log_error($sformatf("echo_char got %h want %h",
                                out_data_o.echo_char, want.echo_char));
          if (out_data_o.shutdown != want.shutdown)
            log_error($sformatf("shutdown got %b want %b",
                                out_data_o.shutdown, want.shutdown));
          if (out_data_o.dropped != want.dropped)
            log_error($sformatf("dropped got %b want %b",
                                out_data_o.dropped, want.dropped));
        end
      end
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    kq_wr     = 0;
    kq_rd     = 0;
    kq_halted = 1'b0;
    kq_polled = 1'b0;
    // Hold reset, then release it for good.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_interrupt();
    test_directed_polled();
    test_queue_overflow();
    test_random_traffic(1'b0, 35, 53, 315);
    test_random_traffic(1'b1, 53, 35, 315);
    test_random_traffic(1'b0, 0, 0, 315);
    test_shutdown();

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
